// File: rtl/core/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length pixel decoder.
`default_nettype none

package pcxrle_pkg;

	// Width of the pixel_total register and its reset value
	localparam int unsigned TOTAL_W = 20;
	localparam logic [TOTAL_W-1:0] PIXEL_TOTAL_RESET = TOTAL_W'(64000);

	// Configuration register byte addresses
	localparam logic [1:0] ADDR_PIXEL_TOTAL = 2'd0;

	// Run header marker and count field
	localparam logic [7:0] RUN_MARK       = 8'hC0;
	localparam logic [7:0] RUN_COUNT_MASK = 8'h3F;

	// One classified byte waiting between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       sof;
		logic       is_hdr;
	} pcxrle_item_t;

	// Back-end status seen by the top-level checks
	typedef struct packed {
		logic       emitting;
		logic [5:0] left;
		logic       pop;
	} pcxrle_status_t;

endpackage

`default_nettype wire

// File: rtl/core/pcx_rle_pixel_decoder_core.sv
// PCX 8-bit run-length decoder: each input byte gives zero or more pixels, one
// per cycle at the output register while out_stall is low. A literal byte gives
// one pixel; a run header gives none; the byte after it gives its clipped run
// count of pixels, so a run holds the back end while it drains. The rate is set
// by the single pixel output register. A two-entry queue sits between the byte
// classifier and the decoder, so input beats keep arriving while a run drains
// until the queue is full. pixel_total lives at byte address 0 and is compared
// against the pixel counter on every byte; once the count reaches it, bytes are
// dropped until start_of_image is set.
`default_nettype none

module pcx_rle_pixel_decoder_core
	import pcxrle_pkg::*;
#(
	parameter int unsigned INDEX_BITS = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [1:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  start_of_image,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 pixel_value,
	output logic [INDEX_BITS-1:0]      pixel_index,
	output logic                       last_of_run,
	output logic                       image_done
);

	logic [TOTAL_W-1:0] pixel_total_q;
	logic               q_valid;
	pcxrle_item_t       q_item;
	logic               q_pop;
	pcxrle_status_t     status;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PIXEL_TOTAL) ? 32'(pixel_total_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_total_q <= PIXEL_TOTAL_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_PIXEL_TOTAL)) begin
			pixel_total_q <= pwdata[TOTAL_W-1:0];
		end
	end

	pcxrle_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.start_of_image (start_of_image),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	pcxrle_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_total (pixel_total_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_value (pixel_value),
		.pixel_index (pixel_index),
		.last_of_run (last_of_run),
		.image_done  (image_done),
		.status      (status)
	);

	// The final pixel of an image always closes the byte's pixels
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last_of_run)
		else $error("image_done without last_of_run");

	// A draining run always has pixels left
	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		status.emitting |-> (status.left != 6'd0))
		else $error("run drain with no pixels left");

	// No byte leaves the queue while a run drains
	a_no_pop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		status.emitting |-> !status.pop)
		else $error("queue pop during run drain");

endmodule

`default_nettype wire

// File: rtl/core/pcxrle_front.sv
// Front end: accepts input beats, classifies each byte and queues it.
`default_nettype none

module pcxrle_front
	import pcxrle_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   data_byte,
	input  wire logic         start_of_image,
	output logic              q_valid,
	output pcxrle_item_t      q_item,
	input  wire logic         q_pop
);

	pcxrle_item_t entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	pcxrle_item_t new_item;

	// Classify the incoming byte
	always_comb begin
		new_item.data   = data_byte;
		new_item.sof    = start_of_image;
		new_item.is_hdr = ((data_byte & RUN_MARK) == RUN_MARK);
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the classified byte
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= new_item;
	end

endmodule

`default_nettype wire

// File: rtl/core/pcxrle_back.sv
// Back end: runs the decode state and emits one pixel beat per cycle while the output is not stalled.
`default_nettype none

module pcxrle_back
	import pcxrle_pkg::*;
#(
	parameter int unsigned INDEX_BITS = 20
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [TOTAL_W-1:0]    pixel_total,
	input  wire logic                  q_valid,
	input  wire pcxrle_item_t          q_item,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 pixel_value,
	output logic [INDEX_BITS-1:0]      pixel_index,
	output logic                       last_of_run,
	output logic                       image_done,
	output pcxrle_status_t             status
);

	localparam int unsigned CW = (INDEX_BITS > TOTAL_W) ? INDEX_BITS : TOTAL_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t                state_q, state_d;
	logic                  pend_q, pend_d;
	logic [5:0]            len_q, len_d;
	logic [INDEX_BITS-1:0] pw_q, pw_d;
	logic [5:0]            left_q, left_d;
	logic [7:0]            val_q, val_d;

	logic                  slot_free;
	logic                  eff_pend;
	logic [5:0]            eff_len;
	logic [INDEX_BITS-1:0] eff_pw;
	logic [INDEX_BITS-1:0] cur_pw;
	logic [CW-1:0]         pw_ext, total_ext, rem;
	logic                  complete;
	logic [5:0]            run_cnt, cnt;
	logic                  emit;
	logic [7:0]            emit_val;
	logic                  emit_last;
	logic                  emit_done;

	assign slot_free = !out_valid || !out_stall;

	// Apply start of image before the byte is handled
	assign eff_pend = q_item.sof ? 1'b0 : pend_q;
	assign eff_len  = q_item.sof ? 6'd0 : len_q;
	assign eff_pw   = q_item.sof ? '0 : pw_q;

	// Pixel counter in use this cycle and the room left in the image
	assign cur_pw    = (state_q == ST_EMIT) ? pw_q : eff_pw;
	assign pw_ext    = CW'(cur_pw);
	assign total_ext = CW'(pixel_total);
	assign complete  = (pw_ext >= total_ext);
	assign rem       = total_ext - pw_ext;

	// Clip a run to what remains
	assign run_cnt = ((rem[CW-1:6] == '0) && (rem[5:0] < eff_len)) ? rem[5:0] : eff_len;

	assign emit_done = ((CW+1)'(pw_ext) + (CW+1)'(1)) == (CW+1)'(total_ext);

	// Decode step
	always_comb begin
		state_d   = state_q;
		pend_d    = pend_q;
		len_d     = len_q;
		pw_d      = pw_q;
		left_d    = left_q;
		val_d     = val_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_val  = q_item.data;
		emit_last = 1'b0;
		cnt       = 6'd0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && slot_free) begin
					q_pop  = 1'b1;
					pend_d = eff_pend;
					len_d  = eff_len;
					pw_d   = eff_pw;
					if (!complete) begin
						if (eff_pend) begin
							pend_d = 1'b0;
							len_d  = 6'd0;
							cnt    = run_cnt;
						end else if (q_item.is_hdr) begin
							pend_d = 1'b1;
							len_d  = q_item.data[5:0] & RUN_COUNT_MASK[5:0];
						end else begin
							cnt = 6'd1;
						end
						// Emit the first pixel now, hold the rest of the run
						if (cnt != 6'd0) begin
							emit      = 1'b1;
							emit_last = (cnt == 6'd1);
							pw_d      = eff_pw + INDEX_BITS'(1);
							if (cnt != 6'd1) begin
								state_d = ST_EMIT;
								left_d  = cnt - 6'd1;
								val_d   = q_item.data;
							end
						end
					end
				end
			end
			ST_EMIT: begin
				emit_val = val_q;
				if (slot_free) begin
					emit      = 1'b1;
					emit_last = (left_q == 6'd1);
					pw_d      = pw_q + INDEX_BITS'(1);
					left_d    = left_q - 6'd1;
					if (left_q == 6'd1)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pend_q    <= 1'b0;
			len_q     <= 6'd0;
			pw_q      <= '0;
			left_q    <= 6'd0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			len_q   <= len_d;
			pw_q    <= pw_d;
			left_q  <= left_d;
			if (slot_free)
				out_valid <= emit;
		end
	end

	// Output register and run value
	always_ff @(posedge clk) begin
		val_q <= val_d;
		if (emit) begin
			pixel_value <= emit_val;
			pixel_index <= cur_pw;
			last_of_run <= emit_last;
			image_done  <= emit_done;
		end
	end

	assign status.emitting = (state_q == ST_EMIT);
	assign status.left     = left_q;
	assign status.pop      = q_pop;

endmodule

`default_nettype wire

// File: dv/tb_pcx_rle_pixel_decoder_core.sv
// Self-checking testbench for the PCX run-length pixel decoder core.
`timescale 1ns / 1ps

module tb_pcx_rle_pixel_decoder_core;
	import pcxrle_pkg::*;

	localparam int unsigned INDEX_W = 20;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [7:0] code;
		logic       sof;
	} beat_t;

	typedef struct packed {
		logic [7:0]         value;
		logic [INDEX_W-1:0] idx;
		logic               last;
		logic               done;
	} pixel_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [1:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          data_byte = '0;
	logic                start_of_image = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [7:0]          pixel_value;
	logic [INDEX_W-1:0]  pixel_index;
	logic                last_of_run;
	logic                image_done;

	beat_t  feed_q[$];
	pixel_t pixel_q[$];

	// Decoder state mirrored by the predictor
	logic [TOTAL_W-1:0]  total_cfg = PIXEL_TOTAL_RESET;
	logic                run_armed = 1'b0;
	logic [5:0]          run_cnt = '0;
	logic [INDEX_W-1:0]  written = '0;

	int unsigned errors = 0;
	int unsigned cycles = 0;
	bit          want_hold = 1'b0;

	pcx_rle_pixel_decoder_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.start_of_image (start_of_image),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_value    (pixel_value),
		.pixel_index    (pixel_index),
		.last_of_run    (last_of_run),
		.image_done     (image_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the pixels that one accepted byte produces
	function automatic void decode_byte(logic [7:0] code, logic sof);
		int unsigned count;
		int unsigned room;
		if (sof) begin
			written = '0;
			run_armed = 1'b0;
			run_cnt = '0;
		end
		if (written >= total_cfg)
			return;
		if (run_armed) begin
			count = run_cnt;
			run_armed = 1'b0;
			run_cnt = '0;
		end else if ((code & RUN_MARK) == RUN_MARK) begin
			run_armed = 1'b1;
			run_cnt = code[5:0];
			return;
		end else begin
			count = 1;
		end
		room = total_cfg - written;
		if (count > room)
			count = room;
		for (int unsigned k = 0; k < count; k++) begin
			pixel_q.push_back('{value: code, idx: written, last: (k + 1 == count),
				done: (int'(written) + 1 == int'(total_cfg))});
			written = written + 1'b1;
		end
	endfunction

	function automatic void push_beat(logic [7:0] code, logic sof);
		feed_q.push_back('{code: code, sof: sof});
	endfunction

	// Queue a well-formed stream with random content and some noise
	task automatic queue_stream(int n, int unsigned total);
		int          made;
		int unsigned est;
		bit          sof_next;
		int          r;
		int          cnt;
		made = 0;
		est = 0;
		sof_next = 1'b1;
		while (made < n) begin
			if (est >= total || $urandom_range(0, 99) < 2) begin
				sof_next = 1'b1;
				est = 0;
			end
			r = $urandom_range(0, 99);
			if (r < 50) begin
				push_beat(8'($urandom_range(0, 191)), sof_next);
				est++;
			end else if (r < 88) begin
				cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
				push_beat(RUN_MARK | 8'(cnt), sof_next);
				push_beat(8'($urandom_range(0, 255)), 1'b0);
				est += cnt;
				made++;
			end else begin
				push_beat(8'($urandom_range(0, 255)),
					($urandom_range(0, 15) == 0) ? 1'b1 : sof_next);
				est++;
			end
			sof_next = 1'b0;
			made++;
		end
	endtask

	// Write pixel_total over the register port: setup then access
	task automatic write_total(logic [TOTAL_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PIXEL_TOTAL;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		total_cfg = val;
	endtask

	// Wait for every beat and pixel, then let the pipeline drain
	task automatic settle();
		while (feed_q.size() != 0 || pixel_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: bursts of beats with random gaps, payload held while stalled
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			start_of_image <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_byte(data_byte, start_of_image);
				void'(feed_q.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (gap_left > 0 || feed_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					data_byte <= feed_q[0].code;
					start_of_image <= feed_q[0].sof;
					burst_left--;
				end
			end
		end
	end

	// Receiver: stall pattern that changes mode, plus one long hold-off
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned mode = 0;
	int unsigned mode_left = 0;
	int unsigned phase_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		logic stall_next;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (want_hold && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(64, 256);
			end
			mode_left--;
			phase_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				case (mode)
					0: stall_next = 1'b0;
					1: stall_next = ($urandom_range(0, 3) == 0);
					2: stall_next = ($urandom_range(0, 9) < 6);
					default: stall_next = (phase_cnt % 3 == 0);
				endcase
			end
			out_stall <= stall_next;
		end
	end

	// Check each pixel beat against the oldest expectation
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				if (errors < 10)
					$display("unexpected pixel: value %h index %0d last %b done %b",
						pixel_value, pixel_index, last_of_run, image_done);
				errors++;
			end else begin
				want = pixel_q.pop_front();
				if (pixel_value !== want.value || pixel_index !== want.idx ||
						last_of_run !== want.last || image_done !== want.done) begin
					if (errors < 10)
						$display("pixel mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
							want.value, want.idx, want.last, want.done,
							pixel_value, pixel_index, last_of_run, image_done);
					errors++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** pcx_rle_pixel_decoder_core: FAILED **");
			$finish;
		end
	end

	initial begin
		int unsigned t;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset total: literals at the edges, zero-length run, longest run
		push_beat(8'h00, 1'b1);
		push_beat(8'hBF, 1'b0);
		push_beat(8'h7F, 1'b0);
		push_beat(8'hC0, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(8'hAA, 1'b0);
		push_beat(8'hC1, 1'b0);
		push_beat(8'hC5, 1'b0);
		push_beat(8'h80, 1'b0);
		settle();

		// Clip a run at the end of the image, then drop bytes past it
		write_total(TOTAL_W'(5));
		push_beat(8'h01, 1'b1);
		push_beat(8'hC8, 1'b0);
		push_beat(8'h12, 1'b0);
		push_beat(8'h33, 1'b0);
		push_beat(8'h10, 1'b1);
		push_beat(8'hC2, 1'b0);
		settle();

		// Lower the total under a pending run: byte dropped, run kept
		write_total(TOTAL_W'(1));
		push_beat(8'h20, 1'b0);
		settle();
		write_total(TOTAL_W'(3));
		push_beat(8'h21, 1'b0);
		settle();

		// Zero total: everything dropped
		write_total('0);
		push_beat(8'h55, 1'b1);
		push_beat(8'hC3, 1'b0);
		settle();

		// Largest total
		write_total(TOTAL_MAX);
		push_beat(8'h7E, 1'b1);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h00, 1'b0);
		settle();

		// Random streams over several totals
		write_total(PIXEL_TOTAL_RESET);
		queue_stream(60, PIXEL_TOTAL_RESET);
		settle();

		t = $urandom_range(2, 300);
		write_total(TOTAL_W'(t));
		queue_stream(60, t);
		settle();

		write_total(TOTAL_W'(1));
		queue_stream(40, 1);
		settle();

		want_hold = 1'b1;
		write_total(TOTAL_MAX);
		queue_stream(80, TOTAL_MAX);
		settle();

		t = $urandom_range(16, 80);
		write_total(TOTAL_W'(t));
		queue_stream(60, t);
		settle();

		if (errors == 0)
			$display("** pcx_rle_pixel_decoder_core: PASSED **");
		else
			$display("** pcx_rle_pixel_decoder_core: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/pcxrle_pkg.sv
rtl/core/pcxrle_front.sv
rtl/core/pcxrle_back.sv
rtl/core/pcx_rle_pixel_decoder_core.sv
dv/tb_pcx_rle_pixel_decoder_core.sv
